/* design/buffer_pool_with_wait_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the buffer pool with wait queue.
// The using module provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_WITH_WAIT_QUEUE_TOP_ASSERT_SVH
`define BUFFER_POOL_WITH_WAIT_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPWQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPWQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bpwq_pkg.sv */
// ----------------------------------------------------------------------------
// bpwq_pkg
// Types and constants shared by the buffer pool with wait queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpwq_pkg;

  // Storage sizes.
  localparam int unsigned POOL_DEPTH = 64;
  localparam int unsigned WAIT_DEPTH = 16;

  // Derived widths.
  localparam int unsigned PoolIdxW = $clog2(POOL_DEPTH);
  localparam int unsigned PoolCntW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned WaitIdxW = $clog2(WAIT_DEPTH);
  localparam int unsigned WaitCntW = $clog2(WAIT_DEPTH + 1);

  // Field widths.
  localparam int unsigned RequesterW = 8;
  localparam int unsigned EntryW     = 6;
  localparam int unsigned BusyW      = 7;
  localparam int unsigned OutageW    = 32;
  localparam int unsigned CfgW       = 7;

  // Pool size after reset.
  localparam int unsigned PoolSizeReset = (64 > POOL_DEPTH) ? POOL_DEPTH : 64;

  typedef enum logic {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RETURN  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_HANDED   = 3'd2,
    ST_FREED    = 3'd3,
    ST_REJECTED = 3'd4
  } status_e;

  typedef struct packed {
    func_e                 func;
    logic [RequesterW-1:0] requester_id;
    logic [EntryW-1:0]     entry_index;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [RequesterW-1:0] grant_requester;
    logic [EntryW-1:0]     grant_entry;
    logic [BusyW-1:0]      held_count;
    logic                  pool_busy;
    logic [OutageW-1:0]    starved_count;
  } out_item_t;

endpackage

`default_nettype wire

/* design/buffer_pool_with_wait_queue_top.sv */
// Buffer pool with a FIFO wait queue. One acquire or return transfer is
// accepted per cycle while in_stall_o is low; its result is registered into
// the output register, or the skid register while the output is stalled.
// That rate rests on the free-list head being updated with each transfer:
// the free-list and wait-queue memories are read ahead at the next head
// address, with a bypass of the write made in the same cycle. A two-entry
// output buffer (output register plus skid register) keeps input transfers
// flowing while a result waits. Free-list slots carry valid bits, so reset
// and a pool size write take effect at once with no clearing pass.
// ----------------------------------------------------------------------------
// buffer_pool_with_wait_queue_top
// Free-list allocator of numbered entries with a FIFO queue of requesters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "buffer_pool_with_wait_queue_top_assert.svh"

module buffer_pool_with_wait_queue_top
  import bpwq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_item_t        in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_item_t            out_data_o
);

  // Free list: memory with valid bits; an unwritten slot reads as its index.
  logic [EntryW-1:0]     free_mem [POOL_DEPTH];
  logic [EntryW-1:0]     free_rd_q;
  logic [POOL_DEPTH-1:0] free_vld_q, free_vld_d;
  logic [PoolIdxW-1:0]   free_head_q, free_head_d;
  logic [PoolIdxW-1:0]   free_tail_q, free_tail_d;
  logic [PoolCntW-1:0]   free_cnt_q, free_cnt_d;
  logic                  free_push;

  // Wait queue of requester ids.
  logic [RequesterW-1:0] wait_mem [WAIT_DEPTH];
  logic [RequesterW-1:0] wait_rd_q;
  logic [WaitIdxW-1:0]   wait_head_q, wait_head_d;
  logic [WaitIdxW-1:0]   wait_tail_q, wait_tail_d;
  logic [WaitCntW-1:0]   wait_cnt_q, wait_cnt_d;
  logic                  wait_push;

  // Counters.
  logic [PoolCntW-1:0] in_use_q, in_use_d;
  logic [OutageW-1:0]  outage_q, outage_d;

  // Output buffer.
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  out_item_t res;

  logic                accept;
  logic                take;
  logic [CfgW-1:0]     size_clamped;
  logic [EntryW-1:0]   head_entry;

  assign accept = in_valid_i && !in_stall_o;
  assign take   = out_valid_q && !out_stall_i;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Clamp a written pool size into 1..POOL_DEPTH.
  always_comb begin
    if (cfg_data_i == '0) begin
      size_clamped = CfgW'(1);
    end else if (cfg_data_i > CfgW'(POOL_DEPTH)) begin
      size_clamped = CfgW'(POOL_DEPTH);
    end else begin
      size_clamped = cfg_data_i;
    end
  end

  // Oldest free entry: stored value once written, else the slot index.
  assign head_entry = free_vld_q[free_head_q] ? free_rd_q : EntryW'(free_head_q);

  // One transfer or a pool size write: pool update and result.
  always_comb begin
    free_head_d = free_head_q;
    free_tail_d = free_tail_q;
    free_cnt_d  = free_cnt_q;
    free_vld_d  = free_vld_q;
    free_push   = 1'b0;
    wait_head_d = wait_head_q;
    wait_tail_d = wait_tail_q;
    wait_cnt_d  = wait_cnt_q;
    wait_push   = 1'b0;
    in_use_d    = in_use_q;
    outage_d    = outage_q;
    res         = '0;
    res.status  = ST_FREED;

    if (cfg_we_i) begin
      // A pool size write refills the free list and empties the queue.
      free_head_d = '0;
      free_tail_d = (PoolCntW'(size_clamped) == PoolCntW'(POOL_DEPTH)) ?
                    '0 : PoolIdxW'(size_clamped);
      free_cnt_d  = PoolCntW'(size_clamped);
      free_vld_d  = '0;
      wait_head_d = '0;
      wait_tail_d = '0;
      wait_cnt_d  = '0;
      in_use_d    = '0;
    end else if (accept) begin
      case (in_data_i.func)
        FUNC_ACQUIRE: begin
          if (free_cnt_q != '0) begin
            res.grant_entry     = head_entry;
            res.grant_requester = in_data_i.requester_id;
            res.status          = ST_GRANTED;
            free_head_d = (free_head_q == PoolIdxW'(POOL_DEPTH - 1)) ?
                          '0 : free_head_q + PoolIdxW'(1);
            free_cnt_d  = free_cnt_q - PoolCntW'(1);
            if (in_use_q != PoolCntW'(POOL_DEPTH)) begin
              in_use_d = in_use_q + PoolCntW'(1);
            end
          end else begin
            if (outage_q != '1) begin
              outage_d = outage_q + OutageW'(1);
            end
            if (wait_cnt_q != WaitCntW'(WAIT_DEPTH)) begin
              wait_push   = 1'b1;
              wait_tail_d = (wait_tail_q == WaitIdxW'(WAIT_DEPTH - 1)) ?
                            '0 : wait_tail_q + WaitIdxW'(1);
              wait_cnt_d  = wait_cnt_q + WaitCntW'(1);
              res.status  = ST_QUEUED;
            end else begin
              res.status  = ST_REJECTED;
            end
          end
        end
        FUNC_RETURN: begin
          if (wait_cnt_q != '0) begin
            // Hand the entry straight to the oldest waiter.
            res.grant_requester = wait_rd_q;
            res.grant_entry     = in_data_i.entry_index;
            res.status          = ST_HANDED;
            wait_head_d = (wait_head_q == WaitIdxW'(WAIT_DEPTH - 1)) ?
                          '0 : wait_head_q + WaitIdxW'(1);
            wait_cnt_d  = wait_cnt_q - WaitCntW'(1);
          end else begin
            if (free_cnt_q != PoolCntW'(POOL_DEPTH)) begin
              free_push   = 1'b1;
              free_vld_d[free_tail_q] = 1'b1;
              free_tail_d = (free_tail_q == PoolIdxW'(POOL_DEPTH - 1)) ?
                            '0 : free_tail_q + PoolIdxW'(1);
              free_cnt_d  = free_cnt_q + PoolCntW'(1);
            end
            if (in_use_q != '0) begin
              in_use_d = in_use_q - PoolCntW'(1);
            end
            res.status = ST_FREED;
          end
        end
        default: begin
          res.status = ST_FREED;
        end
      endcase
    end

    res.held_count    = BusyW'(in_use_d);
    res.pool_busy     = (in_use_d != '0);
    res.starved_count = outage_d;
  end

  // Free-list memory: push at the tail, read ahead at the next head.
  always_ff @(posedge clk_i) begin
    if (free_push) begin
      free_mem[free_tail_q] <= in_data_i.entry_index;
    end
    if (free_push && (free_tail_q == free_head_d)) begin
      free_rd_q <= in_data_i.entry_index;
    end else begin
      free_rd_q <= free_mem[free_head_d];
    end
  end

  // Wait queue storage: push at the tail, read ahead at the next head.
  always_ff @(posedge clk_i) begin
    if (wait_push) begin
      wait_mem[wait_tail_q] <= in_data_i.requester_id;
    end
    if (wait_push && (wait_tail_q == wait_head_d)) begin
      wait_rd_q <= in_data_i.requester_id;
    end else begin
      wait_rd_q <= wait_mem[wait_head_d];
    end
  end

  // Pool control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_tail_q <= (PoolSizeReset == POOL_DEPTH) ? '0 : PoolIdxW'(PoolSizeReset);
      free_cnt_q  <= PoolCntW'(PoolSizeReset);
      free_vld_q  <= '0;
      wait_head_q <= '0;
      wait_tail_q <= '0;
      wait_cnt_q  <= '0;
      in_use_q    <= '0;
      outage_q    <= '0;
    end else begin
      free_head_q <= free_head_d;
      free_tail_q <= free_tail_d;
      free_cnt_q  <= free_cnt_d;
      free_vld_q  <= free_vld_d;
      wait_head_q <= wait_head_d;
      wait_tail_q <= wait_tail_d;
      wait_cnt_q  <= wait_cnt_d;
      in_use_q    <= in_use_d;
      outage_q    <= outage_d;
    end
  end

  // Output buffer valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // Checks on the pool bookkeeping and the output buffer.
  `BPWQ_ASSERT_IMP(a_wait_only_when_empty, wait_cnt_q != '0, free_cnt_q == '0,
                   "requesters wait while free entries remain")
  `BPWQ_ASSERT_IMP(a_skid_implies_out, skid_valid_q, out_valid_q,
                   "skid register holds a result ahead of the output register")
  `BPWQ_ASSERT_IMP(a_counts_bounded, 1'b1,
                   (in_use_q <= PoolCntW'(POOL_DEPTH)) &&
                   (wait_cnt_q <= WaitCntW'(WAIT_DEPTH)) &&
                   (free_cnt_q <= PoolCntW'(POOL_DEPTH)),
                   "pool counter out of range")
  `BPWQ_ASSERT_NXT(a_handoff_keeps_busy,
                   accept && !cfg_we_i && (in_data_i.func == FUNC_RETURN) &&
                   (wait_cnt_q != '0),
                   $stable(in_use_q) && $stable(free_cnt_q),
                   "hand-off to a waiter changed the pool counts")

endmodule

`default_nettype wire

/* bench/buffer_pool_with_wait_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// buffer_pool_with_wait_queue_top_tb
// Drives acquire and return transfers into the buffer pool and checks every
// result against the directed table or an in-bench model of the free list, wait queue and counters.
// A short table of directed steps comes first, then random phases over several
// pool sizes, with random gaps and stalls on both sides and one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buffer_pool_with_wait_queue_top_tb;
  import bpwq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned HOLD_CYCLES  = 40;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 72;
  localparam int unsigned DIR_ROWS     = 17;
  localparam int unsigned IDLE_PCT     = 27;

  // One row of the directed table: a size write or a run of identical items.
  typedef struct {
    bit              is_cfg;
    logic [CfgW-1:0] size_val;
    in_item_t        item;
    int              reps;
    bit              typed;
    out_item_t       want;
  } step_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_data_i;
  logic            in_valid_i;
  logic            in_stall_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_item_t       out_data_o;

  // Pool model state.
  logic [EntryW-1:0]     free_ring [POOL_DEPTH];
  int unsigned           free_rd;
  int unsigned           free_wr;
  int unsigned           free_num;
  logic [RequesterW-1:0] waiters [WAIT_DEPTH];
  int unsigned           wait_rd;
  int unsigned           wait_wr;
  int unsigned           wait_num;
  int unsigned           busy_total;
  logic [OutageW-1:0]    outages;
  int unsigned           pool_entries;

  out_item_t         pending_results [$];
  logic [EntryW-1:0] granted_entries [$];
  int unsigned       error_count;
  int unsigned       cycle_count;
  bit                hold_request;
  bit                steady;
  step_row_t         dir_rows [DIR_ROWS];

  buffer_pool_with_wait_queue_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Prints a line for each of the first 100 mismatches and counts every one.
  task automatic report_error(input string msg);
    if (error_count < 100) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // Refills the free list for a new pool size and empties the wait queue.
  task automatic pool_reinit(input logic [CfgW-1:0] size_val);
    int unsigned v;
    v = size_val;
    if (v < 1) v = 1;
    if (v > POOL_DEPTH) v = POOL_DEPTH;
    pool_entries = v;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      free_ring[i] = (i < v) ? EntryW'(i) : '0;
    end
    free_rd    = 0;
    free_wr    = v % POOL_DEPTH;
    free_num   = v;
    wait_rd    = 0;
    wait_wr    = 0;
    wait_num   = 0;
    busy_total = 0;
    granted_entries.delete();
  endtask

  // Computes the result of one acquire or return and advances the pool.
  task automatic pool_predict(input in_item_t it, output out_item_t res);
    res = '0;
    if (it.func == FUNC_ACQUIRE) begin
      if (free_num > 0) begin
        res.grant_entry     = free_ring[free_rd];
        free_rd             = (free_rd + 1) % POOL_DEPTH;
        free_num--;
        if (busy_total < POOL_DEPTH) busy_total++;
        res.grant_requester = it.requester_id;
        res.status          = ST_GRANTED;
      end else begin
        if (outages != '1) outages++;
        if (wait_num < WAIT_DEPTH) begin
          waiters[wait_wr] = it.requester_id;
          wait_wr          = (wait_wr + 1) % WAIT_DEPTH;
          wait_num++;
          res.status = ST_QUEUED;
        end else begin
          res.status = ST_REJECTED;
        end
      end
    end else begin
      if (wait_num > 0) begin
        res.grant_requester = waiters[wait_rd];
        wait_rd             = (wait_rd + 1) % WAIT_DEPTH;
        wait_num--;
        res.grant_entry = it.entry_index;
        res.status      = ST_HANDED;
      end else begin
        // A full free list drops the returned entry.
        if (free_num < POOL_DEPTH) begin
          free_ring[free_wr] = it.entry_index;
          free_wr            = (free_wr + 1) % POOL_DEPTH;
          free_num++;
        end
        if (busy_total > 0) busy_total--;
        res.status = ST_FREED;
      end
    end
    res.held_count    = BusyW'(busy_total);
    res.pool_busy     = (busy_total != 0);
    res.starved_count = outages;
  endtask

  // Offers one item, waits for its transfer, then records the expected result.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pool_predict(it, res);
    if (res.status == ST_GRANTED || res.status == ST_HANDED) begin
      granted_entries.push_back(res.grant_entry);
    end
    pending_results.push_back(typed ? want : res);
  endtask

  // Writes the pool size once every result has come out.
  task automatic set_pool_size(input logic [CfgW-1:0] size_val);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= size_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_reinit(size_val);
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_error("result transfer with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_error($sformatf("status got %0d expected %0d",
                                 out_data_o.status, want.status));
        if (out_data_o.grant_requester !== want.grant_requester)
          report_error($sformatf("grant_requester got %0d expected %0d",
                                 out_data_o.grant_requester, want.grant_requester));
        if (out_data_o.grant_entry !== want.grant_entry)
          report_error($sformatf("grant_entry got %0d expected %0d",
                                 out_data_o.grant_entry, want.grant_entry));
        if (out_data_o.held_count !== want.held_count)
          report_error($sformatf("held_count got %0d expected %0d",
                                 out_data_o.held_count, want.held_count));
        if (out_data_o.pool_busy !== want.pool_busy)
          report_error($sformatf("pool_busy got %0d expected %0d",
                                 out_data_o.pool_busy, want.pool_busy));
        if (out_data_o.starved_count !== want.starved_count)
          report_error($sformatf("starved_count got %0d expected %0d",
                                 out_data_o.starved_count, want.starved_count));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    logic [CfgW-1:0] phase_sizes [PHASES];
    in_item_t        it;
    int unsigned     acq_pct;
    int unsigned     pick;

    cycle_count  = 0;
    error_count  = 0;
    hold_request = 1'b0;
    steady       = 1'b0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    outages      = '0;
    pool_reinit(CfgW'(PoolSizeReset));

    // Directed steps: reset state, dropped returns, size clamps, a full wait
    // queue with rejection, and a handoff to a waiter.
    dir_rows[0]  = '{1'b0, 7'd0, '{FUNC_ACQUIRE, 8'hFF, 6'd0}, 1, 1'b1,
                     '{ST_GRANTED, 8'hFF, 6'd0, 7'd1, 1'b1, 32'd0}};
    dir_rows[1]  = '{1'b0, 7'd0, '{FUNC_RETURN, 8'h00, 6'd63}, 1, 1'b1,
                     '{ST_FREED, 8'h00, 6'd0, 7'd0, 1'b0, 32'd0}};
    dir_rows[2]  = '{1'b0, 7'd0, '{FUNC_RETURN, 8'h00, 6'd0}, 1, 1'b1,
                     '{ST_FREED, 8'h00, 6'd0, 7'd0, 1'b0, 32'd0}};
    dir_rows[3]  = '{1'b1, 7'd0, '0, 0, 1'b0, '0};
    dir_rows[4]  = '{1'b0, 7'd0, '{FUNC_ACQUIRE, 8'h00, 6'h3F}, 1, 1'b1,
                     '{ST_GRANTED, 8'h00, 6'd0, 7'd1, 1'b1, 32'd0}};
    dir_rows[5]  = '{1'b0, 7'd0, '{FUNC_ACQUIRE, 8'hAA, 6'd0}, 1, 1'b1,
                     '{ST_QUEUED, 8'h00, 6'd0, 7'd1, 1'b1, 32'd1}};
    dir_rows[6]  = '{1'b0, 7'd0, '{FUNC_RETURN, 8'h55, 6'h2A}, 1, 1'b1,
                     '{ST_HANDED, 8'hAA, 6'h2A, 7'd1, 1'b1, 32'd1}};
    dir_rows[7]  = '{1'b0, 7'd0, '{FUNC_ACQUIRE, 8'h55, 6'h15}, WAIT_DEPTH, 1'b0, '0};
    dir_rows[8]  = '{1'b0, 7'd0, '{FUNC_ACQUIRE, 8'h3C, 6'd0}, 1, 1'b1,
                     '{ST_REJECTED, 8'h00, 6'd0, 7'd1, 1'b1, 32'd18}};
    dir_rows[9]  = '{1'b1, 7'd127, '0, 0, 1'b0, '0};
    dir_rows[10] = '{1'b0, 7'd0, '{FUNC_RETURN, 8'h00, 6'h3F}, 1, 1'b1,
                     '{ST_FREED, 8'h00, 6'd0, 7'd0, 1'b0, 32'd18}};
    dir_rows[11] = '{1'b0, 7'd0, '{FUNC_ACQUIRE, 8'h81, 6'h3F}, 1, 1'b1,
                     '{ST_GRANTED, 8'h81, 6'd0, 7'd1, 1'b1, 32'd18}};
    dir_rows[12] = '{1'b1, 7'd2, '0, 0, 1'b0, '0};
    dir_rows[13] = '{1'b0, 7'd0, '{FUNC_ACQUIRE, 8'h7E, 6'h01}, 3, 1'b0, '0};
    dir_rows[14] = '{1'b0, 7'd0, '{FUNC_RETURN, 8'h01, 6'h3F}, 1, 1'b0, '0};
    dir_rows[15] = '{1'b0, 7'd0, '{FUNC_RETURN, 8'hFE, 6'h2A}, 2, 1'b0, '0};
    dir_rows[16] = '{1'b1, 7'd64, '0, 0, 1'b0, '0};

    phase_sizes = '{7'd64, 7'd1, 7'd4, 7'd0, 7'd127, 7'd16,
                    CfgW'($urandom_range(64, 1)), 7'd2,
                    CfgW'($urandom_range(127)), 7'd3};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].is_cfg) begin
        set_pool_size(dir_rows[r].size_val);
      end else begin
        for (int n = 0; n < dir_rows[r].reps; n++) begin
          send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end
      end
    end

    // Random phases; acquire-heavy and return-heavy stretches alternate so
    // the wait queue fills and drains.
    for (int p = 0; p < PHASES; p++) begin
      set_pool_size(phase_sizes[p]);
      steady = (p == 5);
      if (p == 2) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        acq_pct = ((k / 20) % 2 == 0) ? 70 : 30;
        it.requester_id = RequesterW'($urandom_range(255));
        it.entry_index  = EntryW'($urandom_range(63));
        if ($urandom_range(99) < acq_pct) begin
          it.func = FUNC_ACQUIRE;
        end else begin
          it.func = FUNC_RETURN;
          // Mostly return an entry that is actually held.
          if (granted_entries.size() > 0 && $urandom_range(99) < 85) begin
            pick           = $urandom_range(granted_entries.size() - 1);
            it.entry_index = granted_entries[pick];
            granted_entries.delete(pick);
          end
        end
        send_item(it, 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Drain, then let the pipeline settle.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* buffer_pool_with_wait_queue_top.f */
+incdir+design
design/bpwq_pkg.sv
design/buffer_pool_with_wait_queue_top.sv
bench/buffer_pool_with_wait_queue_top_tb.sv
